/* rtl/mm4_pkg.sv */
// Shared types and constants for the 4x4 fixed-point matrix multiply unit.
// No dependencies.
package mm4_pkg;

	localparam int FracBits = 16;
	localparam int Dim      = 4;
	localparam int Cells    = Dim * Dim;

	typedef logic signed [31:0] elem_t;
	typedef logic signed [63:0] prod_t;
	typedef logic signed [64:0] pair_t;
	typedef logic signed [65:0] sum_t;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_MUL  = 1'b1
	} cmd_t;

	localparam elem_t ElemMax = 32'sh7FFF_FFFF;
	localparam elem_t ElemMin = 32'sh8000_0000;

	// advance enables for the accumulate stages
	typedef struct packed {
		logic adv3;
		logic adv4;
	} acc_en_t;

endpackage

/* rtl/mm4_bmat.sv */
// Stored B matrix: 16 registers, row-major, cleared at reset, one row written per load.
// Depends on mm4_pkg.
module mm4_bmat (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [1:0]        wrow,
	input  mm4_pkg::elem_t    wdata [mm4_pkg::Dim],
	output mm4_pkg::elem_t    b_q   [mm4_pkg::Cells]
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mm4_pkg::Cells; i++) begin
				b_q[i] <= '0;
			end
		end else if (we) begin
			for (int k = 0; k < mm4_pkg::Dim; k++) begin
				b_q[{wrow, 2'(k)}] <= wdata[k];
			end
		end
	end

endmodule

/* rtl/mm4_prod.sv */
// Product stage: sixteen 32x32 signed multiplies, shifted by the fraction bits, registered.
// Depends on mm4_pkg.
module mm4_prod (
	input  logic              clk,
	input  logic              en,
	input  mm4_pkg::elem_t    a   [mm4_pkg::Dim],
	input  mm4_pkg::elem_t    b   [mm4_pkg::Cells],
	output mm4_pkg::prod_t    p_s2 [mm4_pkg::Cells]
);

	mm4_pkg::prod_t full [mm4_pkg::Cells];

	// entry k*4+j holds a[k] * B[k][j]
	always_comb begin
		for (int i = 0; i < mm4_pkg::Cells; i++) begin
			full[i] = mm4_pkg::prod_t'(a[i / mm4_pkg::Dim]) * mm4_pkg::prod_t'(b[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < mm4_pkg::Cells; i++) begin
				p_s2[i] <= full[i] >>> mm4_pkg::FracBits;
			end
		end
	end

endmodule

/* rtl/mm4_acc.sv */
// Accumulate stages: pair sums, column totals, then clamp to 32 bits with a row flag.
// Depends on mm4_pkg.
module mm4_acc (
	input  logic              clk,
	input  mm4_pkg::acc_en_t  en,
	input  mm4_pkg::prod_t    p_s2 [mm4_pkg::Cells],
	output mm4_pkg::elem_t    res  [mm4_pkg::Dim],
	output logic              sat
);

	mm4_pkg::pair_t pa_s3  [mm4_pkg::Dim];
	mm4_pkg::pair_t pb_s3  [mm4_pkg::Dim];
	mm4_pkg::sum_t  tot_s4 [mm4_pkg::Dim];
	logic [mm4_pkg::Dim-1:0] ovf;

	always_ff @(posedge clk) begin
		if (en.adv3) begin
			for (int j = 0; j < mm4_pkg::Dim; j++) begin
				pa_s3[j] <= {p_s2[j][63], p_s2[j]} + {p_s2[4 + j][63], p_s2[4 + j]};
				pb_s3[j] <= {p_s2[8 + j][63], p_s2[8 + j]} + {p_s2[12 + j][63], p_s2[12 + j]};
			end
		end
		if (en.adv4) begin
			for (int j = 0; j < mm4_pkg::Dim; j++) begin
				tot_s4[j] <= {pa_s3[j][64], pa_s3[j]} + {pb_s3[j][64], pb_s3[j]};
			end
		end
	end

	// clamp when the bits above bit 31 are not a plain sign extension
	always_comb begin
		for (int j = 0; j < mm4_pkg::Dim; j++) begin
			ovf[j] = !((&tot_s4[j][65:31]) || !(|tot_s4[j][65:31]));
			if (!ovf[j]) begin
				res[j] = tot_s4[j][31:0];
			end else if (tot_s4[j][65]) begin
				res[j] = mm4_pkg::ElemMin;
			end else begin
				res[j] = mm4_pkg::ElemMax;
			end
		end
		sat = |ovf;
	end

endmodule

/* rtl/matrix_multiply_4x4_unit.sv */
// 4x4 signed Q16.16 matrix multiply, one row of A per item against a stored B.
// Path: a multiply item's result reaches the output register through the input reg, product reg,
// pair-sum reg, total reg and output reg. Throughput: one item per cycle unless out_stall backs
// the pipeline up to the input, set by the sixteen parallel multipliers of the product stage.
// Reset (arst_n low, asynchronous): all stage valids clear and B becomes the zero matrix.
// Depends on mm4_pkg, mm4_bmat, mm4_prod, mm4_acc.
module matrix_multiply_4x4_unit (
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                command,
	input  logic [1:0]          row,
	input  mm4_pkg::elem_t      e0,
	input  mm4_pkg::elem_t      e1,
	input  mm4_pkg::elem_t      e2,
	input  mm4_pkg::elem_t      e3,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          out_row,
	output mm4_pkg::elem_t      r0,
	output mm4_pkg::elem_t      r1,
	output mm4_pkg::elem_t      r2,
	output mm4_pkg::elem_t      r3,
	output logic                saturated
);

	// stage valids; out_valid is the fifth stage
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	// stage 1 payload, and the row tags of stages 1 to 4
	mm4_pkg::cmd_t  cmd_s1;
	logic [1:0]     row_s1, row_s2, row_s3, row_s4;
	mm4_pkg::elem_t a_s1 [mm4_pkg::Dim];

	mm4_pkg::elem_t   b_q  [mm4_pkg::Cells];
	mm4_pkg::prod_t   p_s2 [mm4_pkg::Cells];
	mm4_pkg::elem_t   res  [mm4_pkg::Dim];
	logic             sat;
	logic             b_we;
	mm4_pkg::acc_en_t acc_en;

	// A stage takes new data when it is empty or its contents move on this cycle.
	// The chain lets the pipeline keep accepting while bubbles remain anywhere.
	assign rdy5     = !out_valid || !out_stall;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	assign acc_en.adv3 = rdy3;
	assign acc_en.adv4 = rdy4;

	// Commit a load when it leaves stage 1. A multiply reads B in stage 1, so every
	// earlier multiply has already taken its operands and every later one sees the row.
	assign b_we = v_s1 && (cmd_s1 == mm4_pkg::CMD_LOAD) && rdy2;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			// drop loads here: they give no result
			if (rdy2) begin
				v_s2 <= v_s1 && (cmd_s1 == mm4_pkg::CMD_MUL);
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
			if (rdy5) begin
				out_valid <= v_s4;
			end
		end
	end

	// payload registers; hold while the stage is stalled
	always_ff @(posedge clk) begin
		if (rdy1) begin
			cmd_s1  <= mm4_pkg::cmd_t'(command);
			row_s1  <= row;
			a_s1[0] <= e0;
			a_s1[1] <= e1;
			a_s1[2] <= e2;
			a_s1[3] <= e3;
		end
		if (rdy2) begin
			row_s2 <= row_s1;
		end
		if (rdy3) begin
			row_s3 <= row_s2;
		end
		if (rdy4) begin
			row_s4 <= row_s3;
		end
		if (rdy5) begin
			out_row   <= row_s4;
			r0        <= res[0];
			r1        <= res[1];
			r2        <= res[2];
			r3        <= res[3];
			saturated <= sat;
		end
	end

	mm4_bmat u_bmat (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (b_we),
		.wrow   (row_s1),
		.wdata  (a_s1),
		.b_q    (b_q)
	);

	mm4_prod u_prod (
		.clk  (clk),
		.en   (rdy2),
		.a    (a_s1),
		.b    (b_q),
		.p_s2 (p_s2)
	);

	mm4_acc u_acc (
		.clk  (clk),
		.en   (acc_en),
		.p_s2 (p_s2),
		.res  (res),
		.sat  (sat)
	);

	// A load never turns into a result.
	a_load_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && cmd_s1 == mm4_pkg::CMD_LOAD && rdy2) |=> !v_s2)
		else $error("load item reached the product stage as valid");

	// The input backs up only when every stage is full and the output is stalled.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && out_valid && out_stall))
		else $error("input stalled with a free pipeline stage");

	// A flagged row carries at least one clamped element.
	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |->
		(r0 == mm4_pkg::ElemMax || r0 == mm4_pkg::ElemMin ||
		 r1 == mm4_pkg::ElemMax || r1 == mm4_pkg::ElemMin ||
		 r2 == mm4_pkg::ElemMax || r2 == mm4_pkg::ElemMin ||
		 r3 == mm4_pkg::ElemMax || r3 == mm4_pkg::ElemMin))
		else $error("saturated flag without a clamped element");

endmodule
